### rtl/qslp_pkg.sv
// ----------------------------------------------------------------------------
// qslp_pkg: shared types and constants of the quoted string list parser
// Holds the parse mode type, the status codes, the character constants and
// the escape letter decoder.
// ----------------------------------------------------------------------------
package qslp_pkg;

  typedef enum logic [1:0] {
    MODE_OPEN  = 2'd0,
    MODE_STR   = 2'd1,
    MODE_ESC   = 2'd2,
    MODE_COMMA = 2'd3
  } mode_t;

  typedef logic [2:0] status_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_ESC_AT_END = 3'd1;
  localparam status_t ST_BAD_ESC    = 3'd2;
  localparam status_t ST_NO_QUOTE   = 3'd3;
  localparam status_t ST_NO_COMMA   = 3'd4;

  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_V         = 8'h76;

  typedef struct packed {
    logic       ok;
    logic [7:0] ch;
  } esc_t;

  // Maps an escape letter to the character it stands for.
  function automatic esc_t decode_escape(input logic [7:0] c);
    esc_t d;
    d.ok = 1'b1;
    d.ch = 8'h00;
    unique case (c)
      CH_BACKSLASH: d.ch = 8'h5C;
      CH_QUOTE:     d.ch = 8'h22;
      CH_ZERO:      d.ch = 8'h00;
      CH_B:         d.ch = 8'h08;
      CH_N:         d.ch = 8'h0A;
      CH_R:         d.ch = 8'h0D;
      CH_T:         d.ch = 8'h09;
      CH_F:         d.ch = 8'h0C;
      CH_V:         d.ch = 8'h0B;
      default:      d.ok = 1'b0;
    endcase
    return d;
  endfunction

endpackage

### rtl/qslp_if.sv
// ----------------------------------------------------------------------------
// qslp_if: valid/ready channels of the quoted string list parser
// Byte channel into the parser and result channel out of it.
// ----------------------------------------------------------------------------
interface qslp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

interface qslp_out_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           out_char;
  logic                 has_char;
  logic                 element_end;
  qslp_pkg::status_t    status;
  logic                 list_end;
  logic                 partial_dropped;

  modport source (output valid, output out_char, output has_char, output element_end,
                  output status, output list_end, output partial_dropped, input ready);
  modport sink   (input valid, input out_char, input has_char, input element_end,
                  input status, input list_end, input partial_dropped, output ready);
endinterface

### rtl/quoted_string_list_parser.sv
// ----------------------------------------------------------------------------
// quoted_string_list_parser: streaming parser for a list of quoted strings
// Decodes a comma-separated list of double-quoted strings with backslash
// escapes, one raw byte per request, one result per request.
// ----------------------------------------------------------------------------
// Usage:
// The list text enters on in_stream, one byte per request, with is_last
// set on the final byte. Every request yields exactly one result request on
// out_stream: a decoded character, an element-end mark at a closing quote,
// an error status, or an empty result. list_end marks the result of the
// final byte, and partial_dropped tells downstream to discard an element
// that was still open at that point.
// An accepted byte has its result on out_stream from the cycle after on.
// Throughput is one byte per cycle while out_stream takes results; the
// limit is the parse mode register, which is updated by every byte.
// The result register doubles as the skid stage: in_stream.ready is high
// whenever the result register is empty or being taken in the same cycle,
// so a stalled receiver holds the pending result and stops new bytes
// until it takes it.
// After an error the parser sends empty results until the final byte.
// The final byte always returns the parser to waiting for an opening quote.
// A synchronous reset (rst_n low) empties the result register and puts the
// parser into that same start state.
// ----------------------------------------------------------------------------
module quoted_string_list_parser (
  input  logic             clk,
  input  logic             rst_n,
  qslp_in_if.sink          in_stream,
  qslp_out_if.source       out_stream
);

  // Parser state.
  qslp_pkg::mode_t   mode_r, mode_nxt;
  logic              err_r, err_nxt;

  // Mode that the byte leads to before the end of the list forces a restart.
  qslp_pkg::mode_t   mode_step;

  // Result of the current byte.
  logic [7:0]        ch;
  logic              has;
  logic              eend;
  qslp_pkg::status_t status;
  logic              partial;

  // Result register.
  logic              out_valid_r;
  logic [7:0]        out_char_r;
  logic              has_char_r;
  logic              element_end_r;
  qslp_pkg::status_t status_r;
  logic              list_end_r;
  logic              partial_r;

  logic              in_acc;
  qslp_pkg::esc_t    esc;

  // A byte may enter whenever the result register is free this cycle.
  assign in_stream.ready = !out_valid_r || out_stream.ready;
  assign in_acc          = in_stream.valid && in_stream.ready;
  assign esc             = qslp_pkg::decode_escape(in_stream.in_byte);

  // Next state of the parser.
  always_comb begin
    mode_step = mode_r;
    unique case (mode_r)
      qslp_pkg::MODE_OPEN: begin
        if (in_stream.in_byte == qslp_pkg::CH_QUOTE) mode_step = qslp_pkg::MODE_STR;
      end
      qslp_pkg::MODE_COMMA: begin
        if (in_stream.in_byte == qslp_pkg::CH_COMMA) mode_step = qslp_pkg::MODE_OPEN;
      end
      qslp_pkg::MODE_STR: begin
        if (in_stream.in_byte == qslp_pkg::CH_BACKSLASH) begin
          if (!in_stream.is_last) mode_step = qslp_pkg::MODE_ESC;
        end else if (in_stream.in_byte == qslp_pkg::CH_QUOTE) begin
          mode_step = qslp_pkg::MODE_COMMA;
        end
      end
      qslp_pkg::MODE_ESC: begin
        if (esc.ok) mode_step = qslp_pkg::MODE_STR;
      end
      default: mode_step = qslp_pkg::MODE_OPEN;
    endcase

    mode_nxt = mode_r;
    err_nxt  = err_r;
    if (in_acc) begin
      if (!err_r) begin
        mode_nxt = mode_step;
        err_nxt  = (status != qslp_pkg::ST_OK);
      end
      // The final byte always restarts the parser.
      if (in_stream.is_last) begin
        mode_nxt = qslp_pkg::MODE_OPEN;
        err_nxt  = 1'b0;
      end
    end
  end

  // Result of the current byte.
  always_comb begin
    ch      = 8'h00;
    has     = 1'b0;
    eend    = 1'b0;
    status  = qslp_pkg::ST_OK;
    partial = 1'b0;
    if (!err_r) begin
      unique case (mode_r)
        qslp_pkg::MODE_OPEN: begin
          if (in_stream.in_byte != qslp_pkg::CH_QUOTE) status = qslp_pkg::ST_NO_QUOTE;
        end
        qslp_pkg::MODE_COMMA: begin
          if (in_stream.in_byte != qslp_pkg::CH_COMMA) status = qslp_pkg::ST_NO_COMMA;
        end
        qslp_pkg::MODE_STR: begin
          if (in_stream.in_byte == qslp_pkg::CH_BACKSLASH) begin
            if (in_stream.is_last) status = qslp_pkg::ST_ESC_AT_END;
          end else if (in_stream.in_byte == qslp_pkg::CH_QUOTE) begin
            eend = 1'b1;
          end else begin
            ch  = in_stream.in_byte;
            has = 1'b1;
          end
        end
        qslp_pkg::MODE_ESC: begin
          if (esc.ok) begin
            ch  = esc.ch;
            has = 1'b1;
          end else begin
            status = qslp_pkg::ST_BAD_ESC;
          end
        end
        default: status = qslp_pkg::ST_OK;
      endcase
      // An element still open at the final byte is flagged for discarding.
      partial = in_stream.is_last && (status == qslp_pkg::ST_OK) &&
                (mode_step == qslp_pkg::MODE_STR);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= qslp_pkg::MODE_OPEN;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      err_r  <= err_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_stream.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload of the result register; loaded only when a byte is accepted.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_char_r    <= ch;
      has_char_r    <= has;
      element_end_r <= eend;
      status_r      <= status;
      list_end_r    <= in_stream.is_last;
      partial_r     <= partial;
    end
  end

  assign out_stream.valid           = out_valid_r;
  assign out_stream.out_char        = out_char_r;
  assign out_stream.has_char        = has_char_r;
  assign out_stream.element_end     = element_end_r;
  assign out_stream.status          = status_r;
  assign out_stream.list_end        = list_end_r;
  assign out_stream.partial_dropped = partial_r;

  // A result never carries a character and an element end together.
  a_char_xor_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(has_char_r && element_end_r))
    else $error("result carries both a character and an element end");

  // An error result carries no character, no element end and no partial flag.
  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != qslp_pkg::ST_OK) |->
      (!has_char_r && !element_end_r && !partial_r))
    else $error("error result carries payload");

  // The partial flag only appears at the end of the list.
  a_partial_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && partial_r) |-> list_end_r)
    else $error("partial flag before list end");

  // The final byte leaves the parser in its start state.
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_stream.is_last) |=> (mode_r == qslp_pkg::MODE_OPEN && !err_r))
    else $error("parser not restarted after final byte");

  // While errors are held, results are empty.
  a_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && err_r) |=> (!has_char_r && !element_end_r &&
                           status_r == qslp_pkg::ST_OK && !partial_r))
    else $error("result during held error is not empty");

endmodule
